// ----- rtl/core/mccnrpn_pkg.sv -----
package mccnrpn_pkg;

    localparam int DATA_W  = 7;
    localparam int CACHE_N = 128;
    localparam int SUB_N   = 4;
    localparam int SUB_W   = 2;

    // Input item kinds
    localparam logic [1:0] KIND_RX   = 2'd0;
    localparam logic [1:0] KIND_TX   = 2'd1;
    localparam logic [1:0] KIND_NRPN = 2'd2;
    localparam logic [1:0] KIND_NONE = 2'd3;

    // Control change status and NRPN controller numbers
    localparam logic [3:0] CC_STATUS_HI = 4'hB;
    localparam logic [6:0] CC_NRPN_LSB  = 7'h62;
    localparam logic [6:0] CC_NRPN_MSB  = 7'h63;
    localparam logic [6:0] CC_DATA_MSB  = 7'h06;
    localparam logic [6:0] CC_DATA_LSB  = 7'h26;

    // Sub-message slots of an NRPN request
    localparam logic [SUB_W-1:0] SUB_NRPN_LSB = 2'd0;
    localparam logic [SUB_W-1:0] SUB_NRPN_MSB = 2'd1;
    localparam logic [SUB_W-1:0] SUB_DATA_MSB = 2'd2;
    localparam logic [SUB_W-1:0] SUB_DATA_LSB = 2'd3;

    typedef struct packed {
        logic [7:0]        status;
        logic [DATA_W-1:0] data_one;
        logic [DATA_W-1:0] data_two;
    } msg_t;

    // Cache request: one access per cycle
    typedef struct packed {
        logic              wr_en;
        logic              rd_en;
        logic              inval_en;
        logic [DATA_W-1:0] key;
        logic [DATA_W-1:0] value;
    } cache_req_t;

    typedef struct packed {
        logic              valid;
        logic [DATA_W-1:0] value;
    } cache_rsp_t;

    function automatic logic is_cc(input logic [7:0] status);
        return status[7:4] == CC_STATUS_HI;
    endfunction

    // Message for one slot: a plain send uses the item, NRPN expands by slot
    function automatic msg_t msg_sel(
        input logic             nrpn,
        input logic [SUB_W-1:0] idx,
        input msg_t             item,
        input logic [3:0]       chan,
        input logic [13:0]      num,
        input logic [13:0]      dat
    );
        msg_t m;
        m.status = {CC_STATUS_HI, chan};
        case (idx)
            SUB_NRPN_LSB:
            begin
                m.data_one = CC_NRPN_LSB;
                m.data_two = num[6:0];
            end
            SUB_NRPN_MSB:
            begin
                m.data_one = CC_NRPN_MSB;
                m.data_two = num[13:7];
            end
            SUB_DATA_MSB:
            begin
                m.data_one = CC_DATA_MSB;
                m.data_two = dat[13:7];
            end
            SUB_DATA_LSB:
            begin
                m.data_one = CC_DATA_LSB;
                m.data_two = dat[6:0];
            end
            default:
            begin
                m.data_one = CC_NRPN_LSB;
                m.data_two = num[6:0];
            end
        endcase
        if (!nrpn)
        begin
            m = item;
        end
        return m;
    endfunction

endpackage

// ----- rtl/core/midi_cc_nrpn_sender_with_echo_filter_top.sv -----
// Sequence: a received message or unused kind is taken in idle; a CC send goes through
// lookup, compare and emit, a non-CC send straight to emit; an NRPN request goes through
// lookup and compare for each of its slots, then emit for each slot. One request is
// handled at a time, and each emit waits out any output stall.
// Reset: asynchronous, active low; clears all cache valid bits, sequencer and output valid.
module midi_cc_nrpn_sender_with_echo_filter_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  kind,
    input  logic [7:0]  status_byte,
    input  logic [6:0]  data_one,
    input  logic [6:0]  data_two,
    input  logic [3:0]  channel,
    input  logic [13:0] nrpn_number,
    input  logic [13:0] nrpn_data,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_status,
    output logic [6:0]  out_data_one,
    output logic [6:0]  out_data_two,
    output logic        last
);
    import mccnrpn_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_LOOKUP = 4'b0010,
        ST_CHECK  = 4'b0100,
        ST_EMIT   = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    logic              nrpn_reg;
    msg_t              item_reg;
    logic [3:0]        chan_reg;
    logic [13:0]       num_reg;
    logic [13:0]       dat_reg;
    logic [SUB_W-1:0]  idx_reg, idx_next;
    logic [SUB_W-1:0]  last_idx_reg, last_idx_next;
    logic [SUB_N-1:0]  pass_reg, pass_next;
    logic              out_valid_reg, out_valid_next;
    msg_t              out_msg_reg;
    logic              out_last_reg;

    logic              accept;
    logic              out_free;
    logic              out_load;
    msg_t              cur_msg;
    msg_t              in_item;
    logic              later_pass;
    logic              cur_pass;
    cache_req_t        creq;
    cache_rsp_t        crsp;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign out_free = !out_valid_reg || !out_stall;

    assign in_item.status   = status_byte;
    assign in_item.data_one = data_one;
    assign in_item.data_two = data_two;

    assign cur_msg = msg_sel(nrpn_reg, idx_reg, item_reg, chan_reg, num_reg, dat_reg);

    // Filter decision for the current slot
    assign cur_pass = !(is_cc(cur_msg.status) && crsp.valid
                        && (crsp.value == cur_msg.data_two));

    // Any passing slot after the current one
    always_comb
    begin
        later_pass = 1'b0;
        for (int j = 0; j < SUB_N; j++)
        begin
            if ((j > int'(idx_reg)) && pass_reg[j])
            begin
                later_pass = 1'b1;
            end
        end
    end

    assign out_load = (state_reg == ST_EMIT) && pass_reg[idx_reg] && out_free;

    // Cache access: write on receive, read on lookup, invalidate on check
    always_comb
    begin
        creq          = '0;
        creq.key      = cur_msg.data_one;
        creq.value    = data_two;
        case (state_reg)
            ST_IDLE:
            begin
                creq.key   = data_one;
                creq.wr_en = accept && (kind == KIND_RX) && is_cc(status_byte);
            end
            ST_LOOKUP:
            begin
                creq.rd_en = 1'b1;
            end
            ST_CHECK:
            begin
                creq.inval_en = is_cc(cur_msg.status) && crsp.valid
                                && (crsp.value != cur_msg.data_two);
            end
            default:
            begin
                creq.key = cur_msg.data_one;
            end
        endcase
    end

    mccnrpn_cache u_cache (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (creq),
        .rsp   (crsp)
    );

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        last_idx_next  = last_idx_reg;
        pass_next      = pass_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        case (state_reg)
            ST_IDLE:
            begin
                idx_next  = '0;
                pass_next = '0;
                if (accept)
                begin
                    case (kind)
                        KIND_TX:
                        begin
                            last_idx_next = '0;
                            if (is_cc(status_byte))
                            begin
                                state_next = ST_LOOKUP;
                            end
                            else
                            begin
                                pass_next  = SUB_N'(1);
                                state_next = ST_EMIT;
                            end
                        end
                        KIND_NRPN:
                        begin
                            last_idx_next = SUB_W'(SUB_N - 1);
                            state_next    = ST_LOOKUP;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_LOOKUP:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                pass_next[idx_reg] = cur_pass;
                if (idx_reg == last_idx_reg)
                begin
                    idx_next   = '0;
                    state_next = ST_EMIT;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_LOOKUP;
                end
            end
            ST_EMIT:
            begin
                if (!pass_reg[idx_reg] || out_free)
                begin
                    if (idx_reg == last_idx_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            last_idx_reg  <= '0;
            pass_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            last_idx_reg  <= last_idx_next;
            pass_reg      <= pass_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Item capture and output register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            nrpn_reg <= (kind == KIND_NRPN);
            item_reg <= in_item;
            chan_reg <= channel;
            num_reg  <= nrpn_number;
            dat_reg  <= nrpn_data;
        end
        if (out_load)
        begin
            out_msg_reg  <= cur_msg;
            out_last_reg <= !later_pass;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_status   = out_msg_reg.status;
    assign out_data_one = out_msg_reg.data_one;
    assign out_data_two = out_msg_reg.data_two;
    assign last         = out_last_reg;

`ifndef SYNTH
    a_rx_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (kind == KIND_RX || kind == KIND_NONE)) |=> (state_reg == ST_IDLE))
        else $error("received message did not return to idle");
    a_load_only_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_EMIT))
        else $error("output loaded outside emit");
    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> (idx_reg <= last_idx_reg))
        else $error("slot index past last slot");
    a_tx_single_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE && !nrpn_reg) |-> (last_idx_reg == '0))
        else $error("plain send uses more than one slot");
`endif

endmodule

// ----- rtl/core/mccnrpn_cache.sv -----
module mccnrpn_cache (
    input  logic                    clk,
    input  logic                    rst_n,
    input  mccnrpn_pkg::cache_req_t req,
    output mccnrpn_pkg::cache_rsp_t rsp
);
    import mccnrpn_pkg::*;

    logic [CACHE_N-1:0] valid_reg;
    logic [CACHE_N-1:0] valid_next;
    logic [DATA_W-1:0]  value_mem [CACHE_N];
    logic               rd_valid_reg;
    logic [DATA_W-1:0]  rd_value_reg;

    // Valid bits: set on a received control change, cleared on invalidate
    always_comb
    begin
        valid_next = valid_reg;
        if (req.wr_en)
        begin
            valid_next[req.key] = 1'b1;
        end
        else if (req.inval_en)
        begin
            valid_next[req.key] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (req.rd_en)
            begin
                rd_valid_reg <= valid_reg[req.key];
            end
        end
    end

    // Value store, registered read
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            value_mem[req.key] <= req.value;
        end
        if (req.rd_en)
        begin
            rd_value_reg <= value_mem[req.key];
        end
    end

    assign rsp.valid = rd_valid_reg;
    assign rsp.value = rd_value_reg;

`ifndef SYNTH
    a_write_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        req.wr_en |=> valid_reg[$past(req.key)])
        else $error("cache write did not set valid bit");
    a_inval_clears_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (req.inval_en && !req.wr_en) |=> !valid_reg[$past(req.key)])
        else $error("cache invalidate did not clear valid bit");
    a_single_access: assert property (@(posedge clk) disable iff (!rst_n)
        !(req.wr_en && (req.rd_en || req.inval_en)))
        else $error("cache write collides with another access");
`endif

endmodule

// ----- dv/midi_echo_checker.sv -----
`timescale 1ns / 1ps

// Watches both channels of the CC/NRPN sender, predicts the emitted
// messages from each accepted request and compares them in order.
module midi_echo_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [1:0]  kind,
    input  logic [7:0]  status_byte,
    input  logic [6:0]  data_one,
    input  logic [6:0]  data_two,
    input  logic [3:0]  channel,
    input  logic [13:0] nrpn_number,
    input  logic [13:0] nrpn_data,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [7:0]  out_status,
    input  logic [6:0]  out_data_one,
    input  logic [6:0]  out_data_two,
    input  logic        last,
    output int          fail_count,
    output int          pending
);

    import mccnrpn_pkg::*;

    localparam int MAX_REPORTS = 100;

    typedef struct packed {
        logic [7:0] status;
        logic [6:0] data_one;
        logic [6:0] data_two;
        logic       last;
    } midi_msg_t;

    // Echo cache as seen by the predictor
    logic [6:0] echo_value [0:CACHE_N-1];
    logic       echo_seen  [0:CACHE_N-1];

    midi_msg_t expected_msgs [$];
    midi_msg_t request_msgs [0:SUB_N-1];
    int        request_len;
    midi_msg_t got_msg;
    midi_msg_t want_msg;
    int        fail_total = 0;
    int        queued = 0;

    assign fail_count = fail_total;
    assign pending    = queued;

    function automatic void note_failure();
        fail_total++;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            note_failure();
            // keep the log readable on a badly broken block
            if (fail_total <= MAX_REPORTS)
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        end
    endfunction

    // Echo filter on one outgoing message; survivors join the current request
    task automatic filter_msg(input logic [7:0] st, input logic [6:0] d1, input logic [6:0] d2);
        if (st[7:4] == CC_STATUS_HI && echo_seen[d1])
        begin
            if (echo_value[d1] == d2)
                return;
            echo_seen[d1] = 1'b0;
        end
        request_msgs[request_len] = {st, d1, d2, 1'b0};
        request_len++;
    endtask

    task automatic predict_request(input logic [1:0] k, input logic [7:0] st,
                                   input logic [6:0] d1, input logic [6:0] d2,
                                   input logic [3:0] ch, input logic [13:0] num,
                                   input logic [13:0] dat);
        logic [7:0] cc_status;
        cc_status   = {CC_STATUS_HI, ch};
        request_len = 0;
        case (k)
            KIND_RX:
            begin
                if (st[7:4] == CC_STATUS_HI)
                begin
                    echo_value[d1] = d2;
                    echo_seen[d1]  = 1'b1;
                end
            end
            KIND_TX:
                filter_msg(st, d1, d2);
            KIND_NRPN:
            begin
                filter_msg(cc_status, CC_NRPN_LSB, num[6:0]);
                filter_msg(cc_status, CC_NRPN_MSB, num[13:7]);
                filter_msg(cc_status, CC_DATA_MSB, dat[13:7]);
                filter_msg(cc_status, CC_DATA_LSB, dat[6:0]);
            end
            default:
            begin
            end
        endcase
        if (request_len > 0)
            request_msgs[request_len-1].last = 1'b1;
        for (int i = 0; i < request_len; i++)
            expected_msgs = {expected_msgs, request_msgs[i]};
    endtask

    // Results are compared before the request of the same edge is predicted
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CACHE_N; i++)
                echo_seen[i] = 1'b0;
            expected_msgs.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                got_msg = {out_status, out_data_one, out_data_two, last};
                if (expected_msgs.size() == 0)
                begin
                    note_failure();
                    if (fail_total <= MAX_REPORTS)
                        $error("unexpected message: status 0x%0h data 0x%0h 0x%0h last %0b",
                               got_msg.status, got_msg.data_one, got_msg.data_two,
                               got_msg.last);
                end
                else
                begin
                    want_msg = expected_msgs.pop_front();
                    check_field("out_status", want_msg.status, got_msg.status);
                    check_field("out_data_one", want_msg.data_one, got_msg.data_one);
                    check_field("out_data_two", want_msg.data_two, got_msg.data_two);
                    check_field("last", want_msg.last, got_msg.last);
                end
            end
            if (in_valid && !in_stall)
                predict_request(kind, status_byte, data_one, data_two, channel,
                                nrpn_number, nrpn_data);
        end
        queued = expected_msgs.size();
    end

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps

module tb;

    import mccnrpn_pkg::*;

    localparam int RANDOM_REQUESTS = 360;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int HOLD_AFTER      = 60;
    localparam int HOLD_CYCLES     = 400;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  kind;
    logic [7:0]  status_byte;
    logic [6:0]  data_one;
    logic [6:0]  data_two;
    logic [3:0]  channel;
    logic [13:0] nrpn_number;
    logic [13:0] nrpn_data;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  out_status;
    logic [6:0]  out_data_one;
    logic [6:0]  out_data_two;
    logic        last;

    int fail_count;
    int pending;
    int cycle_count = 0;
    int burst_left = 0;

    always #5 clk = ~clk;

    midi_cc_nrpn_sender_with_echo_filter_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .kind         (kind),
        .status_byte  (status_byte),
        .data_one     (data_one),
        .data_two     (data_two),
        .channel      (channel),
        .nrpn_number  (nrpn_number),
        .nrpn_data    (nrpn_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_status   (out_status),
        .out_data_one (out_data_one),
        .out_data_two (out_data_two),
        .last         (last)
    );

    midi_echo_checker echo_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .kind         (kind),
        .status_byte  (status_byte),
        .data_one     (data_one),
        .data_two     (data_two),
        .channel      (channel),
        .nrpn_number  (nrpn_number),
        .nrpn_data    (nrpn_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_status   (out_status),
        .out_data_one (out_data_one),
        .out_data_two (out_data_two),
        .last         (last),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[midi_cc_nrpn_sender_with_echo_filter_top] ERROR");
            $finish;
        end
    end

    // Controller numbers biased toward the NRPN ones and the edges
    function automatic logic [6:0] pick_key();
        if ($urandom_range(0, 1) == 0)
            return 7'($urandom);
        case ($urandom_range(0, 7))
            0: return CC_NRPN_LSB;
            1: return CC_NRPN_MSB;
            2: return CC_DATA_MSB;
            3: return CC_DATA_LSB;
            4: return 7'd0;
            5: return 7'd127;
            6: return 7'd1;
            default: return 7'd2;
        endcase
    endfunction

    // Small values repeat often so echoes actually match
    function automatic logic [6:0] pick_val();
        if ($urandom_range(0, 1) == 0)
            return 7'($urandom_range(0, 3));
        return 7'($urandom);
    endfunction

    // Offer one request, wait for it to be taken, then idle for a random gap, often none
    task automatic send_req(input logic [1:0] k, input logic [7:0] st,
                            input logic [6:0] d1, input logic [6:0] d2,
                            input logic [3:0] ch, input logic [13:0] num,
                            input logic [13:0] dat);
        int gap;
        int r;
        in_valid    <= 1'b1;
        kind        <= k;
        status_byte <= st;
        data_one    <= d1;
        data_two    <= d2;
        channel     <= ch;
        nrpn_number <= num;
        nrpn_data   <= dat;
        do
            @(posedge clk);
        while (in_stall);
        r = $urandom_range(0, 99);
        if (burst_left > 0)
        begin
            burst_left--;
            gap = 0;
        end
        else if (r < 3)
        begin
            burst_left = $urandom_range(10, 40);
            gap = 0;
        end
        else if (r < 55)
            gap = 0;
        else if (r < 88)
            gap = $urandom_range(1, 3);
        else if (r < 96)
            gap = $urandom_range(4, 12);
        else
            gap = $urandom_range(20, 60);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_msg(input logic [1:0] k, input logic [7:0] st,
                            input logic [6:0] d1, input logic [6:0] d2);
        send_req(k, st, d1, d2, 4'($urandom), 14'($urandom), 14'($urandom));
    endtask

    task automatic send_nrpn(input logic [3:0] ch, input logic [13:0] num,
                             input logic [13:0] dat);
        send_req(KIND_NRPN, 8'($urandom), 7'($urandom), 7'($urandom), ch, num, dat);
    endtask

    // Stop offering until every expected message has come out
    task automatic wait_quiet();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    // Receiver: random stall runs, free runs, and one long hold-off
    initial
    begin
        int  stall_run;
        int  free_run;
        int  taken;
        int  r;
        bit  held;
        stall_run = 0;
        free_run  = 0;
        taken     = 0;
        held      = 1'b0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
                taken++;
            if (!held && taken >= HOLD_AFTER)
            begin
                held = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
            end
            else
            begin
                if (stall_run == 0 && free_run == 0)
                begin
                    r = $urandom_range(0, 99);
                    if (r < 50)
                        free_run = $urandom_range(1, 8);
                    else if (r < 60)
                        free_run = $urandom_range(40, 120);
                    else if (r < 92)
                        stall_run = $urandom_range(1, 3);
                    else
                        stall_run = $urandom_range(10, 40);
                end
                if (stall_run > 0)
                begin
                    out_stall <= 1'b1;
                    stall_run--;
                end
                else
                begin
                    out_stall <= 1'b0;
                    free_run--;
                end
            end
        end
    end

    // Sender: reset, directed requests, random requests, verdict
    initial
    begin
        int         counted;
        int         r;
        bit         paused;
        logic [6:0] key;
        logic [6:0] val;
        logic [3:0] ch;
        logic [3:0] other_ch;
        logic [13:0] num;
        logic [13:0] dat;

        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        kind        <= KIND_RX;
        status_byte <= 8'h00;
        data_one    <= 7'd0;
        data_two    <= 7'd0;
        channel     <= 4'd0;
        nrpn_number <= 14'd0;
        nrpn_data   <= 14'd0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Plain sends at the field extremes, CC and non-CC
        send_msg(KIND_TX, {CC_STATUS_HI, 4'h0}, 7'd0, 7'd0);
        send_msg(KIND_TX, 8'hFF, 7'd127, 7'd127);
        send_msg(KIND_TX, 8'h00, 7'd5, 7'd9);
        send_msg(KIND_TX, 8'hC0, 7'd7, 7'd3);
        // Echo hit drops, a miss invalidates, the next identical send passes
        send_msg(KIND_RX, {CC_STATUS_HI, 4'hF}, 7'd10, 7'd20);
        send_msg(KIND_TX, {CC_STATUS_HI, 4'h3}, 7'd10, 7'd20);
        send_msg(KIND_TX, {CC_STATUS_HI, 4'h0}, 7'd10, 7'd21);
        send_msg(KIND_TX, {CC_STATUS_HI, 4'h0}, 7'd10, 7'd20);
        // Received non-CC leaves the cache alone
        send_msg(KIND_RX, 8'h90, 7'd11, 7'd5);
        send_msg(KIND_TX, {CC_STATUS_HI, 4'h0}, 7'd11, 7'd5);
        send_msg(KIND_NONE, 8'hB0, 7'd11, 7'd5);
        // NRPN at the extremes
        send_nrpn(4'h0, 14'h0000, 14'h0000);
        send_nrpn(4'hF, 14'h3FFF, 14'h3FFF);
        // Fully echoed NRPN emits nothing
        send_msg(KIND_RX, {CC_STATUS_HI, 4'h0}, CC_NRPN_LSB, 7'h34);
        send_msg(KIND_RX, {CC_STATUS_HI, 4'h7}, CC_NRPN_MSB, 7'h24);
        send_msg(KIND_RX, {CC_STATUS_HI, 4'h0}, CC_DATA_MSB, 7'h15);
        send_msg(KIND_RX, {CC_STATUS_HI, 4'h0}, CC_DATA_LSB, 7'h3C);
        send_nrpn(4'h5, 14'h1234, 14'h0ABC);
        // New data: only the data entry pair goes out
        send_nrpn(4'h5, 14'h1234, 14'h2ABD);
        // Last flag lands on the data MSB when the data LSB is filtered
        send_msg(KIND_RX, {CC_STATUS_HI, 4'h0}, CC_DATA_LSB, 7'h3D);
        send_nrpn(4'h5, 14'h1234, 14'h2ABD);
        wait_quiet();

        // Random requests, many of them echo/send sequences
        counted = 0;
        paused  = 1'b0;
        while (counted < RANDOM_REQUESTS)
        begin
            if (!paused && counted >= RANDOM_REQUESTS / 2)
            begin
                paused = 1'b1;
                wait_quiet();
            end
            r = $urandom_range(0, 99);
            if (r < 25)
            begin
                // received CC then a send on the same controller
                key = pick_key();
                val = pick_val();
                ch  = 4'($urandom);
                send_msg(KIND_RX, {CC_STATUS_HI, ch}, key, val);
                counted++;
                if ($urandom_range(0, 3) != 0)
                begin
                    ch = 4'($urandom);
                    if ($urandom_range(0, 2) == 0)
                        val = val + 7'd1;
                    send_msg(KIND_TX, {CC_STATUS_HI, ch}, key, val);
                    counted++;
                    if ($urandom_range(0, 1) == 0)
                    begin
                        send_msg(KIND_TX, {CC_STATUS_HI, ch}, key, val);
                        counted++;
                    end
                end
            end
            else if (r < 40)
            begin
                // some NRPN bytes echoed back first, then the request
                ch  = 4'($urandom);
                num = 14'($urandom);
                dat = 14'($urandom);
                for (int n = 0; n < SUB_N; n++)
                begin
                    case (n)
                        0:
                        begin
                            key = CC_NRPN_LSB;
                            val = num[6:0];
                        end
                        1:
                        begin
                            key = CC_NRPN_MSB;
                            val = num[13:7];
                        end
                        2:
                        begin
                            key = CC_DATA_MSB;
                            val = dat[13:7];
                        end
                        default:
                        begin
                            key = CC_DATA_LSB;
                            val = dat[6:0];
                        end
                    endcase
                    if ($urandom_range(0, 1) == 1)
                    begin
                        if ($urandom_range(0, 4) == 0)
                            val = 7'($urandom);
                        other_ch = 4'($urandom);
                        send_msg(KIND_RX, {CC_STATUS_HI, other_ch}, key, val);
                        counted++;
                    end
                end
                send_nrpn(ch, num, dat);
                counted++;
            end
            else if (r < 60)
            begin
                ch = 4'($urandom);
                send_msg(KIND_TX, {CC_STATUS_HI, ch}, pick_key(), pick_val());
                counted++;
            end
            else if (r < 70)
            begin
                send_nrpn(4'($urandom), 14'($urandom), 14'($urandom));
                counted++;
            end
            else if (r < 80)
            begin
                ch = 4'($urandom);
                send_msg(KIND_RX, {CC_STATUS_HI, ch}, pick_key(), pick_val());
                counted++;
            end
            else if (r < 90)
            begin
                send_msg(KIND_TX, 8'($urandom), 7'($urandom), 7'($urandom));
                counted++;
            end
            else if (r < 95)
            begin
                // received non-CC: ignored, not counted
                num = 14'($urandom);
                if (num[7:4] == CC_STATUS_HI)
                    num[6] = ~num[6];
                send_msg(KIND_RX, num[7:0], 7'($urandom), 7'($urandom));
            end
            else
                send_req(KIND_NONE, 8'($urandom), 7'($urandom), 7'($urandom),
                         4'($urandom), 14'($urandom), 14'($urandom));
        end

        wait_quiet();
        repeat (20) @(posedge clk);
        @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("[midi_cc_nrpn_sender_with_echo_filter_top] OK");
        else
            $display("[midi_cc_nrpn_sender_with_echo_filter_top] ERROR");
        $finish;
    end

endmodule
